// ===== src/rcs_pkg.sv =====
// Package for the rank counting sort block: payload types, controller
// command and status structs, and default sizing. No dependencies.

package rcs_pkg;

  // Default capacity of one set.
  localparam int RCS_MAX_ITEMS = 64;

  // Input transaction payload.
  typedef struct packed {
    logic signed [31:0] value;
    logic               end_of_set;
  } rcs_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               end_of_run;
    logic               overflow;
  } rcs_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;      // take the accepted input value into the input store
    logic issue;      // read the next compare operand and advance the scan index
    logic place;      // write the ranked key to the sorted store, next key
    logic out_load;   // load the output register with the next sorted value
    logic clear_set;  // reset fill count and drop flag for the next set
  } rcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic j_last;     // scan index is at the last loaded entry
    logic i_last;     // key or emit index is at the last loaded entry
    logic out_busy;   // output register holds a result that is not taken
  } rcs_status_t;

endpackage

// ===== src/rcs_ctrl.sv =====
// Controller state machine of the rank counting sort block.
// Depends on rcs_pkg for the command and status structs.

module rcs_ctrl
  import rcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_end,
  output logic        in_ready,
  input  rcs_status_t status,
  output rcs_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_PLACE,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Commands follow directly from the state, the status and the input handshake.
  always_comb begin
    cmd           = '0;
    in_ready      = (state_r == S_LOAD);
    state_nxt     = state_r;
    unique case (state_r)
      S_LOAD: begin
        cmd.store = in_valid;
        if (in_valid && in_end) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (status.j_last) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = status.i_last ? S_EMIT_RD : S_SCAN;
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (!status.out_busy) begin
          cmd.out_load  = 1'b1;
          cmd.clear_set = status.i_last;
          state_nxt     = status.i_last ? S_LOAD : S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/rcs_datapath.sv =====
// Datapath of the rank counting sort block: input and sorted stores, index
// counters, the signed comparator with rank accumulator, and the output register.
// Depends on rcs_pkg for payload types and the command and status structs.

module rcs_datapath
  import rcs_pkg::*;
#(
  parameter int MAX_ITEMS = RCS_MAX_ITEMS
)(
  input  logic        clk,
  input  logic        rst_n,
  input  rcs_in_t     in_data,
  input  rcs_cmd_t    cmd,
  output rcs_status_t status,
  input  logic        out_ready,
  output logic        out_valid,
  output rcs_out_t    out_data
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  // Stores.
  logic signed [31:0] in_mem [MAX_ITEMS];
  logic signed [31:0] sorted_mem [MAX_ITEMS];

  // Control registers.
  logic [CW-1:0] count_r;
  logic          dropped_r;
  logic [AW-1:0] i_r;
  logic [AW-1:0] j_r;
  logic [AW-1:0] j_d_r;
  logic          cmp_vld_r;
  logic [AW-1:0] rank_r;
  logic          out_valid_r;

  // Registered read data.
  logic signed [31:0] key_r;
  logic signed [31:0] opnd_r;
  logic signed [31:0] srt_r;
  rcs_out_t           out_data_r;

  logic [CW-1:0] n_m1;
  logic          not_full;
  logic          hit;
  logic [AW-1:0] place_addr;

  assign n_m1     = count_r - CW'(1);
  assign not_full = (count_r < CW'(MAX_ITEMS));

  // An operand counts when it is smaller than the key, or equal and arrived earlier.
  assign hit = cmp_vld_r &&
               ((opnd_r < key_r) || ((opnd_r == key_r) && (j_d_r < i_r)));
  assign place_addr = rank_r + AW'(hit);

  assign status.j_last   = (CW'(j_r) == n_m1);
  assign status.i_last   = (CW'(i_r) == n_m1);
  assign status.out_busy = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Input store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.store && not_full) begin
      in_mem[count_r[AW-1:0]] <= in_data.value;
    end
    key_r  <= in_mem[i_r];
    opnd_r <= in_mem[j_r];
  end

  // Sorted store: written at the final rank, read for emission.
  always_ff @(posedge clk) begin
    if (cmd.place) begin
      sorted_mem[place_addr] <= key_r;
    end
    srt_r <= sorted_mem[i_r];
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.sorted_value <= srt_r;
      out_data_r.end_of_run   <= status.i_last;
      out_data_r.overflow     <= dropped_r;
    end
  end

  // Counters, rank accumulator and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dropped_r   <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      j_d_r       <= '0;
      cmp_vld_r   <= 1'b0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Fill count and drop flag.
      if (cmd.clear_set) begin
        count_r   <= '0;
        dropped_r <= 1'b0;
      end else if (cmd.store) begin
        if (not_full) begin
          count_r <= count_r + CW'(1);
        end else begin
          dropped_r <= 1'b1;
        end
      end

      // Scan pipeline: operand read, then compare in the cycle after.
      cmp_vld_r <= cmd.issue;
      j_d_r     <= j_r;
      if (cmd.place) begin
        j_r <= '0;
      end else if (cmd.issue) begin
        j_r <= j_r + AW'(1);
      end

      // Rank accumulator.
      if (cmd.place) begin
        rank_r <= '0;
      end else if (hit) begin
        rank_r <= rank_r + AW'(1);
      end

      // Key index during ranking, emit index during output.
      if (cmd.place || cmd.out_load) begin
        i_r <= status.i_last ? '0 : i_r + AW'(1);
      end

      // Output valid.
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== src/rank_count_sort.sv =====
// Top level of the stable rank counting sort block.
// Depends on rcs_pkg, rcs_ctrl and rcs_datapath.
//
//   channel  ports                          payload
//   in       in_valid, in_ready, in_data    rcs_in_t  (value, end_of_set)
//   out      out_valid, out_ready, out_data rcs_out_t (sorted_value, end_of_run, overflow)
//
// Loading accepts one input transaction per cycle. After the end of a set of n
// values, ranking runs one comparator that scans all n stored values for each
// key and then places the key. Emission then passes through a read state and a
// load state for each result, since the sorted store's read is registered.
// Reset is synchronous and active low and clears all control state; the stores
// need no clearing. A stall on the result channel holds emission; the input
// channel is ready only while a set is loading.

module rank_count_sort
  import rcs_pkg::*;
#(
  parameter int MAX_ITEMS = RCS_MAX_ITEMS
)(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rcs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rcs_out_t out_data
);

  rcs_cmd_t    cmd;
  rcs_status_t status;

  // Sequencer.
  rcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_end   (in_data.end_of_set),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Stores, comparator and output register.
  rcs_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // At most one of store, issue, place and out_load is commanded in any cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.store, cmd.issue, cmd.place, cmd.out_load}))
    else $error("more than one datapath command at once");

  // The transaction that ends a set stops loading until the run is out.
  a_end_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.end_of_set |=> !in_ready)
    else $error("input still ready after the end of a set");

  // A key is placed only right after the last operand of its scan was issued.
  a_place_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place |-> $past(cmd.issue))
    else $error("key placed without a completed scan");

endmodule

// ===== tb/rank_count_sort_checker.sv =====
// Checker for the rank counting sort block: watches both channels, predicts
// each sorted run and compares every result field by field.
// Depends on rcs_pkg for the payload types and the default capacity.
`timescale 1ns / 100ps

module rank_count_sort_checker
  import rcs_pkg::*;
#(
  parameter int MAX_ITEMS = RCS_MAX_ITEMS
)(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  rcs_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  rcs_out_t out_data,
  output int       errors,
  output int       pending
);

  // Values of the set being loaded, in arrival order.
  logic signed [31:0] set_values [MAX_ITEMS];
  int                 set_count;
  bit                 set_dropped;

  // Sorted results still owed by the block, oldest first.
  rcs_out_t sorted_run_q [$];

  // Rank every loaded value and queue the run in ascending order. Ties are
  // broken by arrival order, which keeps the sort stable.
  task automatic rank_set_into_queue();
    logic signed [31:0] ranked [MAX_ITEMS];
    int                 rank;
    rcs_out_t           res;
    for (int i = 0; i < set_count; i++) begin
      rank = 0;
      for (int j = 0; j < set_count; j++) begin
        if (set_values[j] < set_values[i] || (set_values[j] == set_values[i] && j < i)) begin
          rank++;
        end
      end
      ranked[rank] = set_values[i];
    end
    for (int k = 0; k < set_count; k++) begin
      res.sorted_value = ranked[k];
      res.end_of_run   = (k == set_count - 1);
      res.overflow     = set_dropped;
      sorted_run_q.push_back(res);
    end
  endtask

  // Compare one result transaction against the oldest expectation.
  task automatic compare_result(input rcs_out_t got);
    rcs_out_t exp;
    exp = sorted_run_q.pop_front();
    if (got.sorted_value !== exp.sorted_value) begin
      $display("%0t: sorted_value mismatch, expected %0d, got %0d",
               $time, exp.sorted_value, got.sorted_value);
      errors++;
    end
    if (got.end_of_run !== exp.end_of_run) begin
      $display("%0t: end_of_run mismatch, expected %0b, got %0b",
               $time, exp.end_of_run, got.end_of_run);
      errors++;
    end
    if (got.overflow !== exp.overflow) begin
      $display("%0t: overflow mismatch, expected %0b, got %0b",
               $time, exp.overflow, got.overflow);
      errors++;
    end
  endtask

  // Sample both channels at each rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      set_count   = 0;
      set_dropped = 0;
      errors      = 0;
      sorted_run_q.delete();
    end else begin
      // Input transaction: store or drop, and rank at the end of the set.
      if (in_valid && in_ready) begin
        if (set_count < MAX_ITEMS) begin
          set_values[set_count] = in_data.value;
          set_count++;
        end else begin
          set_dropped = 1;
        end
        if (in_data.end_of_set) begin
          rank_set_into_queue();
          set_count   = 0;
          set_dropped = 0;
        end
      end
      // Result transaction.
      if (out_valid && out_ready) begin
        if (sorted_run_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got value %0d",
                   $time, out_data.sorted_value);
          errors++;
        end else begin
          compare_result(out_data);
        end
      end
    end
    pending = sorted_run_q.size();
  end

endmodule

// ===== tb/rank_count_sort_tb.sv =====
// Testbench top for the rank counting sort block: clock, reset, input sets
// with random gaps, a randomly stalling result sink and the final verdict.
// Depends on rcs_pkg, rank_count_sort and rank_count_sort_checker.
`timescale 1ns / 100ps

module rank_count_sort_tb;
  import rcs_pkg::*;

  localparam int SET_CAP          = RCS_MAX_ITEMS;
  localparam int SMALL_SET_ITEMS  = 50;
  localparam int END_DRAIN_CYCLES = 20;
  localparam int MAX_GAP          = 12;

  // How the values of one set are drawn.
  typedef enum int {
    VAL_FULL,     // any 32-bit pattern
    VAL_NARROW,   // a few values near zero, so duplicates are common
    VAL_EXTREME   // the signed limits and their neighbors, minus one and zero
  } value_flavor_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  rcs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rcs_out_t out_data;

  int errors;
  int pending;
  int items_sent = 0;
  bit tx_burst = 0;
  bit rx_burst = 0;
  int rx_stall = 0;

  always #5 clk = ~clk;

  rank_count_sort #(
    .MAX_ITEMS(SET_CAP)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  rank_count_sort_checker #(
    .MAX_ITEMS(SET_CAP)
  ) checker_i (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .errors   (errors),
    .pending  (pending)
  );

  // Result sink: after each transaction it stalls for a random number of
  // cycles, with occasional stretches of no stalling at all.
  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall  <= 0;
    end else if (out_valid && out_ready) begin
      if ($urandom_range(0, 19) == 0) begin
        rx_burst <= ~rx_burst;
      end
      n = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      rx_stall  <= n;
      out_ready <= (n == 0);
    end else if (rx_stall > 0) begin
      rx_stall  <= rx_stall - 1;
      out_ready <= (rx_stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic signed [31:0] draw_value(input value_flavor_t flavor);
    int t;
    case (flavor)
      VAL_NARROW: begin
        t = $urandom_range(0, 8);
        draw_value = t - 4;
      end
      VAL_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       draw_value = 32'sh8000_0000;
          1:       draw_value = 32'sh8000_0001;
          2:       draw_value = 32'sh7fff_ffff;
          3:       draw_value = 32'sh7fff_fffe;
          4:       draw_value = -32'sd1;
          default: draw_value = 32'sd0;
        endcase
      end
      default: draw_value = $urandom;
    endcase
  endfunction

  // Present one input transaction after a random gap and wait until it is
  // taken. Called right after a rising edge; returns right after the edge
  // that accepted the transaction.
  task automatic send_item(input logic signed [31:0] v, input logic eos);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data.value      <= v;
    in_data.end_of_set <= eos;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Send a whole set of random values; the last one carries the end mark.
  task automatic send_set(input int n);
    value_flavor_t flavor;
    flavor   = value_flavor_t'($urandom_range(0, 2));
    tx_burst = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < n; k++) begin
      send_item(draw_value(flavor), k == n - 1);
    end
  endtask

  // Hold off the input until every expected result has been taken.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sets: single maximum, single minimum, mixed extremes,
    // duplicates, already ascending and descending input.
    send_item(32'sh7fff_ffff, 1'b1);
    send_item(32'sh8000_0000, 1'b1);
    send_item(32'sd0, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(-32'sd2, 1'b1);
    send_item(32'sd3, 1'b0);
    send_item(-32'sd3, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(-32'sd3, 1'b1);
    send_item(-32'sd2, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(32'sd1, 1'b1);
    send_item(32'sd2, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(-32'sd1, 1'b1);
    wait_results_drained();

    // Random sets, mostly small, sometimes with the input held off.
    while (items_sent < SMALL_SET_ITEMS + 21) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      send_set(n);
      if ($urandom_range(0, 5) == 0) begin
        wait_results_drained();
      end
    end

    // A set that overflows: the store fills up, then a plain item and the
    // end item are both dropped. A short set follows to check the restart.
    send_set(SET_CAP + 2);
    send_set($urandom_range(1, 4));

    wait_results_drained();
    repeat (END_DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** rank_count_sort: PASSED **");
    end else begin
      $display("** rank_count_sort: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("** rank_count_sort: FAILED **");
    $finish;
  end

endmodule
